// ===== rtl/core/fda_pkg.sv =====
// Shared types and constants for the per-process descriptor allocator.
// Used by fda_probe and the top level under rtl/core; depends on nothing else.
package fda_pkg;

  // Default sizes of the process table and of one descriptor table.
  localparam int NumSlotsDef = 16;
  localparam int NumFdsDef   = 64;

  // Descriptors 0..2 are the standard ones.
  localparam int StdFds    = 3;
  localparam int LastStdFd = 2;

  // Field widths.
  localparam int ActionW  = 2;
  localparam int ProcIdW  = 22;
  localparam int DescInW  = 8;
  localparam int DescOutW = 6;
  localparam int InodeW   = 16;
  localparam int ModeW    = 2;
  localparam int StatusW  = 2;
  localparam int EntryW   = InodeW + ModeW;

  typedef enum logic [ActionW-1:0] {
    ACT_OPEN   = 2'd0,
    ACT_LOOKUP = 2'd1,
    ACT_CLOSE  = 2'd2
  } action_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK      = 2'd0,
    ST_NO_FD   = 2'd1,
    ST_NO_FREE = 2'd2,
    ST_NO_SLOT = 2'd3
  } status_e;

  typedef enum logic [ModeW-1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_RW    = 2'd2
  } mode_e;

  // Operations of the shared compare unit.
  typedef enum logic {
    PROBE_PID = 1'b0,
    PROBE_BIT = 1'b1
  } probe_op_e;

endpackage

// ===== rtl/core/fda_ram.sv =====
// Generic simple dual-port RAM with a registered read port.
// Depends on nothing; instanced for every table of the allocator.
module fda_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/fda_probe.sv =====
// Shared compare unit: process-id match for the slot search, and
// descriptor bit test for the free scan and the lookup/close check.
// Depends on fda_pkg.
module fda_probe #(
  parameter int NUM_FDS = fda_pkg::NumFdsDef,
  localparam int FW     = $clog2(NUM_FDS)
) (
  input  fda_pkg::probe_op_e              op_i,
  input  logic                            valid_i,
  input  logic [fda_pkg::ProcIdW-1:0]     pid_a_i,
  input  logic [fda_pkg::ProcIdW-1:0]     pid_b_i,
  input  logic [NUM_FDS-1:0]              bitmap_i,
  input  logic [FW-1:0]                   index_i,
  output logic                            hit_o
);

  // A slot matches when it is live and owned by the process; a bit hits
  // when the descriptor is in use.
  always_comb begin
    case (op_i)
      fda_pkg::PROBE_PID: hit_o = valid_i && (pid_a_i == pid_b_i);
      fda_pkg::PROBE_BIT: hit_o = bitmap_i[index_i];
      default:            hit_o = 1'b0;
    endcase
  end

endmodule

// ===== rtl/core/per_process_fd_allocator_unit.sv =====
// Top level of the per-process descriptor allocator: sequencer, slot valid
// bits and the three table RAMs. Depends on fda_pkg, fda_ram, fda_probe.
//
// Serves open, lookup and close requests one at a time, one result per
// request. The slot search reads the process-id RAM and runs it through the
// single compare unit slot by slot, a read state and then a compare state
// for each, stopping at the first match or after the last slot. An open then
// tests one descriptor per cycle from descriptor 3 upward on the same compare
// unit, up to descriptor NUM_FDS-1. Lookup of a non-standard descriptor adds
// a read of the entry RAM. Input capture, the bitmap read of a known process
// and the result hand-off have states of their own, and an open or a close of
// a non-standard descriptor adds a state for its table write. A finished
// result sits in the output register while the next request is accepted.
module per_process_fd_allocator_unit #(
  parameter int NUM_SLOTS = fda_pkg::NumSlotsDef,
  parameter int NUM_FDS   = fda_pkg::NumFdsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [fda_pkg::ActionW-1:0]      action_i,
  input  logic [fda_pkg::ProcIdW-1:0]      process_id_i,
  input  logic [fda_pkg::DescInW-1:0]      descriptor_i,
  input  logic [fda_pkg::InodeW-1:0]       inode_number_i,
  input  logic [fda_pkg::ModeW-1:0]        access_mode_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [fda_pkg::StatusW-1:0]      status_o,
  output logic [fda_pkg::DescOutW-1:0]     descriptor_out_o,
  output logic [fda_pkg::InodeW-1:0]       inode_out_o,
  output logic [fda_pkg::ModeW-1:0]        mode_out_o
);

  localparam int SW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int FW  = $clog2(NUM_FDS);
  localparam int EAW = $clog2(NUM_SLOTS * NUM_FDS);
  localparam logic [NUM_FDS-1:0] StdMask = NUM_FDS'((1 << fda_pkg::StdFds) - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SRD, S_SCMP, S_BRD, S_BWAIT, S_FSCAN,
    S_OWR, S_ERD, S_EWAIT, S_CWR, S_EMIT
  } state_e;

  state_e                          state_q, state_d;
  logic [NUM_SLOTS-1:0]            valid_q, valid_d;
  logic [fda_pkg::ActionW-1:0]     action_q, action_d;
  logic [fda_pkg::ProcIdW-1:0]     pid_q, pid_d;
  logic [fda_pkg::DescInW-1:0]     fd_q, fd_d;
  logic [fda_pkg::InodeW-1:0]      ino_q, ino_d;
  logic [fda_pkg::ModeW-1:0]       mode_q, mode_d;
  logic [SW-1:0]                   idx_q, idx_d;
  logic [SW-1:0]                   slot_q, slot_d;
  logic [SW-1:0]                   free_q, free_d;
  logic                            free_found_q, free_found_d;
  logic [FW-1:0]                   fd_idx_q, fd_idx_d;
  logic [NUM_FDS-1:0]              bitmap_q, bitmap_d;
  fda_pkg::status_e                res_status_q, res_status_d;
  logic [fda_pkg::DescOutW-1:0]    res_desc_q, res_desc_d;
  logic [fda_pkg::InodeW-1:0]      res_ino_q, res_ino_d;
  logic [fda_pkg::ModeW-1:0]       res_mode_q, res_mode_d;
  logic                            out_valid_q, out_valid_d;
  logic [fda_pkg::StatusW-1:0]     out_status_q, out_status_d;
  logic [fda_pkg::DescOutW-1:0]    out_desc_q, out_desc_d;
  logic [fda_pkg::InodeW-1:0]      out_ino_q, out_ino_d;
  logic [fda_pkg::ModeW-1:0]       out_mode_q, out_mode_d;

  // RAM controls.
  logic                            pid_we, pid_re;
  logic [SW-1:0]                   pid_waddr, pid_raddr;
  logic [fda_pkg::ProcIdW-1:0]     pid_rdata;
  logic                            bm_we, bm_re;
  logic [NUM_FDS-1:0]              bm_wdata, bm_rdata;
  logic                            ent_we, ent_re;
  logic [EAW-1:0]                  ent_addr;
  logic [fda_pkg::EntryW-1:0]      ent_rdata;

  // Compare unit controls.
  fda_pkg::probe_op_e              probe_op;
  logic [NUM_FDS-1:0]              probe_bitmap;
  logic [FW-1:0]                   probe_index;
  logic                            probe_hit;

  logic                            in_xfer;
  logic [SW-1:0]                   free_now;
  logic                            have_free;
  logic                            fd_in_range;
  logic [NUM_FDS-1:0]              fd_onehot;
  logic [NUM_FDS-1:0]              cleared;
  logic [fda_pkg::DescInW-1:0]     fd_idx_ext;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;

  // Entry address: slot-major table of inode and mode per descriptor.
  assign ent_addr    = EAW'(slot_q) * EAW'(NUM_FDS) + EAW'(fd_idx_q);
  assign fd_onehot   = NUM_FDS'(1) << fd_idx_q;
  assign cleared     = bitmap_q & ~fd_onehot;
  assign fd_idx_ext  = fda_pkg::DescInW'(fd_idx_q);
  assign fd_in_range = {1'b0, fd_q} < (fda_pkg::DescInW + 1)'(NUM_FDS);
  assign have_free   = free_found_q || !valid_q[idx_q];
  assign free_now    = free_found_q ? free_q : idx_q;

  // Next-state and datapath control of the sequencer.
  always_comb begin
    state_d      = state_q;
    valid_d      = valid_q;
    action_d     = action_q;
    pid_d        = pid_q;
    fd_d         = fd_q;
    ino_d        = ino_q;
    mode_d       = mode_q;
    idx_d        = idx_q;
    slot_d       = slot_q;
    free_d       = free_q;
    free_found_d = free_found_q;
    fd_idx_d     = fd_idx_q;
    bitmap_d     = bitmap_q;
    res_status_d = res_status_q;
    res_desc_d   = res_desc_q;
    res_ino_d    = res_ino_q;
    res_mode_d   = res_mode_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_desc_d   = out_desc_q;
    out_ino_d    = out_ino_q;
    out_mode_d   = out_mode_q;

    pid_we       = 1'b0;
    pid_re       = 1'b0;
    pid_waddr    = free_now;
    pid_raddr    = idx_q;
    bm_we        = 1'b0;
    bm_re        = 1'b0;
    bm_wdata     = bitmap_q | fd_onehot;
    ent_we       = 1'b0;
    ent_re       = 1'b0;

    probe_op     = fda_pkg::PROBE_PID;
    probe_bitmap = bitmap_q;
    probe_index  = fd_idx_q;

    case (state_q)
      // Capture the request and map the access mode.
      S_IDLE: begin
        if (in_xfer) begin
          action_d     = action_i;
          pid_d        = process_id_i;
          fd_d         = descriptor_i;
          ino_d        = inode_number_i;
          idx_d        = '0;
          free_found_d = 1'b0;
          if (access_mode_i[0]) begin
            mode_d = fda_pkg::MODE_WRITE;
          end else if (access_mode_i[1]) begin
            mode_d = fda_pkg::MODE_RW;
          end else begin
            mode_d = fda_pkg::MODE_READ;
          end
          if (action_i == fda_pkg::ACT_OPEN || action_i == fda_pkg::ACT_LOOKUP ||
              action_i == fda_pkg::ACT_CLOSE) begin
            state_d = S_SRD;
          end else begin
            res_status_d = fda_pkg::ST_NO_FD;
            res_desc_d   = '0;
            res_ino_d    = '0;
            res_mode_d   = '0;
            state_d      = S_EMIT;
          end
        end
      end

      // Slot search: read one process id.
      S_SRD: begin
        pid_re  = 1'b1;
        state_d = S_SCMP;
      end

      // Slot search: compare, remember the lowest free slot on the way.
      S_SCMP: begin
        probe_op = fda_pkg::PROBE_PID;
        if (probe_hit) begin
          slot_d  = idx_q;
          state_d = S_BRD;
        end else begin
          if (!valid_q[idx_q] && !free_found_q) begin
            free_d       = idx_q;
            free_found_d = 1'b1;
          end
          if (idx_q == SW'(NUM_SLOTS - 1)) begin
            res_ino_d  = '0;
            res_mode_d = '0;
            if (action_q == fda_pkg::ACT_OPEN) begin
              if (have_free) begin
                valid_d[free_now] = 1'b1;
                pid_we            = 1'b1;
                slot_d            = free_now;
                bitmap_d          = StdMask;
                fd_idx_d          = FW'(fda_pkg::StdFds);
                state_d           = S_FSCAN;
              end else begin
                res_status_d = fda_pkg::ST_NO_SLOT;
                res_desc_d   = '0;
                state_d      = S_EMIT;
              end
            end else begin
              res_status_d = fda_pkg::ST_NO_FD;
              res_desc_d   = fd_q[fda_pkg::DescOutW-1:0];
              state_d      = S_EMIT;
            end
          end else begin
            idx_d   = idx_q + SW'(1);
            state_d = S_SRD;
          end
        end
      end

      // Read the descriptor bitmap of the found slot.
      S_BRD: begin
        bm_re   = 1'b1;
        state_d = S_BWAIT;
      end

      // Bitmap is in; open scans it, lookup and close check the one bit.
      S_BWAIT: begin
        bitmap_d     = bm_rdata;
        probe_op     = fda_pkg::PROBE_BIT;
        probe_bitmap = bm_rdata;
        probe_index  = fd_q[FW-1:0];
        res_ino_d    = '0;
        res_mode_d   = '0;
        res_desc_d   = fd_q[fda_pkg::DescOutW-1:0];
        if (action_q == fda_pkg::ACT_OPEN) begin
          fd_idx_d = FW'(fda_pkg::StdFds);
          state_d  = S_FSCAN;
        end else if (!fd_in_range || !probe_hit) begin
          res_status_d = fda_pkg::ST_NO_FD;
          state_d      = S_EMIT;
        end else if (fd_q <= fda_pkg::DescInW'(fda_pkg::LastStdFd)) begin
          res_status_d = fda_pkg::ST_OK;
          state_d      = S_EMIT;
        end else begin
          fd_idx_d = fd_q[FW-1:0];
          state_d  = (action_q == fda_pkg::ACT_LOOKUP) ? S_ERD : S_CWR;
        end
      end

      // Lowest free descriptor, one bit per cycle.
      S_FSCAN: begin
        probe_op = fda_pkg::PROBE_BIT;
        if (!probe_hit) begin
          state_d = S_OWR;
        end else if (fd_idx_q == FW'(NUM_FDS - 1)) begin
          res_status_d = fda_pkg::ST_NO_FREE;
          res_desc_d   = '0;
          res_ino_d    = '0;
          res_mode_d   = '0;
          state_d      = S_EMIT;
        end else begin
          fd_idx_d = fd_idx_q + FW'(1);
        end
      end

      // Record the new descriptor.
      S_OWR: begin
        bm_we        = 1'b1;
        bm_wdata     = bitmap_q | fd_onehot;
        ent_we       = 1'b1;
        res_status_d = fda_pkg::ST_OK;
        res_desc_d   = fd_idx_ext[fda_pkg::DescOutW-1:0];
        res_ino_d    = '0;
        res_mode_d   = '0;
        state_d      = S_EMIT;
      end

      // Lookup of a non-standard descriptor reads the entry.
      S_ERD: begin
        ent_re  = 1'b1;
        state_d = S_EWAIT;
      end

      S_EWAIT: begin
        res_status_d = fda_pkg::ST_OK;
        res_ino_d    = ent_rdata[fda_pkg::EntryW-1:fda_pkg::ModeW];
        res_mode_d   = ent_rdata[fda_pkg::ModeW-1:0];
        state_d      = S_EMIT;
      end

      // Close: drop the bit; release the slot when only standard ones remain.
      S_CWR: begin
        bm_we        = 1'b1;
        bm_wdata     = cleared;
        if (cleared == StdMask) begin
          valid_d[slot_q] = 1'b0;
        end
        res_status_d = fda_pkg::ST_OK;
        state_d      = S_EMIT;
      end

      // Hand the result to the output register once it is free.
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_desc_d   = res_desc_q;
          out_ino_d    = res_ino_q;
          out_mode_d   = res_mode_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Sequencer state, slot valid bits and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      valid_q      <= '0;
      action_q     <= '0;
      pid_q        <= '0;
      fd_q         <= '0;
      ino_q        <= '0;
      mode_q       <= '0;
      idx_q        <= '0;
      slot_q       <= '0;
      free_q       <= '0;
      free_found_q <= 1'b0;
      fd_idx_q     <= '0;
      bitmap_q     <= '0;
      res_status_q <= fda_pkg::ST_OK;
      res_desc_q   <= '0;
      res_ino_q    <= '0;
      res_mode_q   <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_desc_q   <= '0;
      out_ino_q    <= '0;
      out_mode_q   <= '0;
    end else begin
      state_q      <= state_d;
      valid_q      <= valid_d;
      action_q     <= action_d;
      pid_q        <= pid_d;
      fd_q         <= fd_d;
      ino_q        <= ino_d;
      mode_q       <= mode_d;
      idx_q        <= idx_d;
      slot_q       <= slot_d;
      free_q       <= free_d;
      free_found_q <= free_found_d;
      fd_idx_q     <= fd_idx_d;
      bitmap_q     <= bitmap_d;
      res_status_q <= res_status_d;
      res_desc_q   <= res_desc_d;
      res_ino_q    <= res_ino_d;
      res_mode_q   <= res_mode_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_desc_q   <= out_desc_d;
      out_ino_q    <= out_ino_d;
      out_mode_q   <= out_mode_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign descriptor_out_o = out_desc_q;
  assign inode_out_o      = out_ino_q;
  assign mode_out_o       = out_mode_q;

  // Shared compare unit.
  fda_probe #(
    .NUM_FDS (NUM_FDS)
  ) u_probe (
    .op_i     (probe_op),
    .valid_i  (valid_q[idx_q]),
    .pid_a_i  (pid_rdata),
    .pid_b_i  (pid_q),
    .bitmap_i (probe_bitmap),
    .index_i  (probe_index),
    .hit_o    (probe_hit)
  );

  // Process id of each slot.
  fda_ram #(
    .WIDTH (fda_pkg::ProcIdW),
    .DEPTH (NUM_SLOTS)
  ) u_pid_ram (
    .clk_i   (clk_i),
    .we_i    (pid_we),
    .waddr_i (pid_waddr),
    .wdata_i (pid_q),
    .re_i    (pid_re),
    .raddr_i (pid_raddr),
    .rdata_o (pid_rdata)
  );

  // Descriptor bitmap of each slot.
  fda_ram #(
    .WIDTH (NUM_FDS),
    .DEPTH (NUM_SLOTS)
  ) u_bitmap_ram (
    .clk_i   (clk_i),
    .we_i    (bm_we),
    .waddr_i (slot_q),
    .wdata_i (bm_wdata),
    .re_i    (bm_re),
    .raddr_i (slot_q),
    .rdata_o (bm_rdata)
  );

  // Inode and mode of each descriptor of each slot.
  fda_ram #(
    .WIDTH (fda_pkg::EntryW),
    .DEPTH (NUM_SLOTS * NUM_FDS)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_addr),
    .wdata_i ({ino_q, mode_q}),
    .re_i    (ent_re),
    .raddr_i (ent_addr),
    .rdata_o (ent_rdata)
  );

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the per-process descriptor allocator.
// Depends on fda_pkg and per_process_fd_allocator_unit; a table model inside
// predicts every result, which is checked field by field in arrival order.
module tb_top;
  import fda_pkg::*;

  localparam int NumSlots    = NumSlotsDef;
  localparam int NumFds      = NumFdsDef;
  localparam int PoolSize    = 20;
  localparam int PhaseItems  = 105;
  localparam int HoldCycles  = 400;
  localparam int DrainCycles = 200;
  localparam int CycleLimit  = 1000000;

  // One result of the block, as the ports carry it.
  typedef struct packed {
    status_e              status;
    logic [DescOutW-1:0]  desc;
    logic [InodeW-1:0]    inode;
    logic [ModeW-1:0]     mode;
  } fd_result_t;

  // Model of the process table and the queue of results it predicts.
  class fd_table_model;
    bit                   slot_live [NumSlots];
    logic [ProcIdW-1:0]   slot_pid  [NumSlots];
    int                   slot_count[NumSlots];
    bit [NumFds-1:0]      slot_map  [NumSlots];
    logic [InodeW-1:0]    ent_inode [NumSlots][NumFds];
    logic [ModeW-1:0]     ent_mode  [NumSlots][NumFds];
    fd_result_t           expected_results[$];
    int                   err_count;

    function new();
      foreach (slot_live[k]) slot_live[k] = 1'b0;
      err_count = 0;
    endfunction

    // Lowest live slot owned by the process, or -1.
    function int find_slot(logic [ProcIdW-1:0] pid);
      for (int k = 0; k < NumSlots; k++) begin
        if (slot_live[k] && slot_pid[k] == pid) return k;
      end
      return -1;
    endfunction

    // Some descriptor in use in a live slot, standard ones included.
    function int pick_open_fd(int s);
      int start;
      int f;
      start = $urandom_range(NumFds - 1);
      for (int i = 0; i < NumFds; i++) begin
        f = (start + i) % NumFds;
        if (slot_map[s][f]) return f;
      end
      return 0;
    endfunction

    // Apply one accepted request to the table and queue the result it gives.
    function void note_request(logic [ActionW-1:0] act, logic [ProcIdW-1:0] pid,
                               logic [DescInW-1:0] fd, logic [InodeW-1:0] ino,
                               logic [ModeW-1:0] am);
      fd_result_t res;
      int s;
      int free_fd;
      logic [ModeW-1:0] md;
      res = '0;
      s = find_slot(pid);
      case (act)
        ACT_OPEN: begin
          if (s < 0) begin
            for (int k = 0; k < NumSlots; k++) begin
              if (!slot_live[k] && s < 0) s = k;
            end
            if (s >= 0) begin
              slot_live[s]  = 1'b1;
              slot_pid[s]   = pid;
              slot_count[s] = StdFds;
              slot_map[s]   = '0;
              for (int f = 0; f < StdFds; f++) slot_map[s][f] = 1'b1;
            end
          end
          if (s < 0) begin
            res.status = ST_NO_SLOT;
          end else begin
            free_fd = -1;
            for (int f = StdFds; f < NumFds; f++) begin
              if (!slot_map[s][f] && free_fd < 0) free_fd = f;
            end
            if (free_fd < 0) begin
              res.status = ST_NO_FREE;
            end else begin
              // Mode three resolves to write, since bit 0 wins.
              if (am[0]) md = MODE_WRITE;
              else if (am[1]) md = MODE_RW;
              else md = MODE_READ;
              slot_map[s][free_fd]  = 1'b1;
              slot_count[s]++;
              ent_inode[s][free_fd] = ino;
              ent_mode[s][free_fd]  = md;
              res.status = ST_OK;
              res.desc   = free_fd[DescOutW-1:0];
            end
          end
        end
        ACT_LOOKUP, ACT_CLOSE: begin
          res.desc = fd[DescOutW-1:0];
          if (s < 0 || fd >= NumFds || !slot_map[s][fd]) begin
            res.status = ST_NO_FD;
          end else if (act == ACT_LOOKUP) begin
            res.status = ST_OK;
            if (fd > LastStdFd) begin
              res.inode = ent_inode[s][fd];
              res.mode  = ent_mode[s][fd];
            end
          end else begin
            // Closing a standard descriptor changes nothing.
            res.status = ST_OK;
            if (fd > LastStdFd) begin
              slot_map[s][fd] = 1'b0;
              slot_count[s]--;
              if (slot_count[s] == StdFds) slot_live[s] = 1'b0;
            end
          end
        end
        default: begin
          res.status = ST_NO_FD;
        end
      endcase
      expected_results.push_back(res);
    endfunction

    function void report(string field, int exp_val, int act_val);
      err_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_val, act_val);
    endfunction

    // Compare one result transfer with the oldest prediction.
    function void check_result(fd_result_t got);
      fd_result_t exp_res;
      if (expected_results.size() == 0) begin
        err_count++;
        $display("%0t: result with no request pending, status %0d desc %0d",
                 $time, got.status, got.desc);
        return;
      end
      exp_res = expected_results.pop_front();
      if (got.status !== exp_res.status) report("status", exp_res.status, got.status);
      if (got.desc !== exp_res.desc) report("descriptor", exp_res.desc, got.desc);
      if (got.inode !== exp_res.inode) report("inode", exp_res.inode, got.inode);
      if (got.mode !== exp_res.mode) report("mode", exp_res.mode, got.mode);
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [ActionW-1:0]   action_i = '0;
  logic [ProcIdW-1:0]   process_id_i = '0;
  logic [DescInW-1:0]   descriptor_i = '0;
  logic [InodeW-1:0]    inode_number_i = '0;
  logic [ModeW-1:0]     access_mode_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [StatusW-1:0]   status_o;
  logic [DescOutW-1:0]  descriptor_out_o;
  logic [InodeW-1:0]    inode_out_o;
  logic [ModeW-1:0]     mode_out_o;

  fd_table_model        fd_model = new();
  int                   tx_idle_pct = 0;
  int                   rx_stall_pct = 0;
  bit                   pressure_on = 1'b0;
  bit                   rx_hold = 1'b0;
  int                   cycle_count = 0;
  logic [ProcIdW-1:0]   pid_pool[PoolSize];

  per_process_fd_allocator_unit DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .process_id_i     (process_id_i),
    .descriptor_i     (descriptor_i),
    .inode_number_i   (inode_number_i),
    .access_mode_i    (access_mode_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .descriptor_out_o (descriptor_out_o),
    .inode_out_o      (inode_out_o),
    .mode_out_o       (mode_out_o)
  );

  always #1 clk_i = ~clk_i;

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: check each transfer, then pick the next ready value.
  always @(posedge clk_i) begin
    fd_result_t got;
    if (out_valid_o && out_ready_i) begin
      got.status = status_e'(status_o);
      got.desc   = descriptor_out_o;
      got.inode  = inode_out_o;
      got.mode   = mode_out_o;
      fd_model.check_result(got);
    end
    if (rx_hold) out_ready_i <= 1'b0;
    else out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
  end

  // Long receiver hold-off so that the block backs up and stalls its input.
  initial begin
    wait (pressure_on);
    rx_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // Offer one request and return once its transfer has taken place.
  task automatic send_request(input logic [ActionW-1:0] act, input logic [ProcIdW-1:0] pid,
                              input logic [DescInW-1:0] fd, input logic [InodeW-1:0] ino,
                              input logic [ModeW-1:0] am);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    action_i       <= act;
    process_id_i   <= pid;
    descriptor_i   <= fd;
    inode_number_i <= ino;
    access_mode_i  <= am;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    fd_model.note_request(act, pid, fd, ino, am);
  endtask

  // Mostly well-formed traffic on a pool of processes, with some noise.
  task automatic send_random_request();
    int r;
    int s;
    logic [ProcIdW-1:0] pid;
    logic [DescInW-1:0] fd;
    logic [ActionW-1:0] act;
    r   = $urandom_range(99);
    pid = pid_pool[$urandom_range(PoolSize - 1)];
    s   = fd_model.find_slot(pid);
    if (r < 38) begin
      send_request(ACT_OPEN, pid, DescInW'($urandom_range(255)),
                   InodeW'($urandom_range(16'hFFFF)), ModeW'($urandom_range(3)));
    end else if (r < 88) begin
      act = (r < 60) ? ACT_LOOKUP : ACT_CLOSE;
      if (s >= 0 && $urandom_range(9) != 0) fd = DescInW'(fd_model.pick_open_fd(s));
      else fd = DescInW'($urandom_range(NumFds + 4));
      send_request(act, pid, fd, InodeW'($urandom_range(16'hFFFF)),
                   ModeW'($urandom_range(3)));
    end else begin
      if ($urandom_range(1)) pid = ProcIdW'($urandom_range(22'h3FFFFF));
      send_request(ActionW'($urandom_range(3)), pid, DescInW'($urandom_range(255)),
                   InodeW'($urandom_range(16'hFFFF)), ModeW'($urandom_range(3)));
    end
  endtask

  initial begin
    int s;
    pid_pool[0] = '0;
    pid_pool[1] = '1;
    for (int i = 2; i < PoolSize; i++) pid_pool[i] = ProcIdW'($urandom_range(22'h3FFFFF));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: unknown process, unused action, mode encodings, standard
    // descriptors, out-of-range and unused descriptors, reuse and slot release.
    send_request(ACT_LOOKUP, 22'd0, 8'd0, 16'd0, 2'd0);
    send_request(ACT_CLOSE, 22'h3FFFFF, 8'd5, 16'hFFFF, 2'd3);
    send_request(2'd3, 22'd0, 8'd255, 16'hFFFF, 2'd3);
    send_request(ACT_OPEN, 22'd0, 8'd0, 16'h0000, MODE_READ);
    send_request(ACT_OPEN, 22'd0, 8'd255, 16'hFFFF, MODE_WRITE);
    send_request(ACT_OPEN, 22'd0, 8'd0, 16'h1234, MODE_RW);
    send_request(ACT_OPEN, 22'd0, 8'd0, 16'hABCD, 2'd3);
    send_request(ACT_OPEN, 22'h3FFFFF, 8'd0, 16'h5555, MODE_READ);
    send_request(2'd3, 22'd0, 8'd3, 16'd0, 2'd0);
    send_request(ACT_LOOKUP, 22'd0, 8'd0, 16'd0, 2'd0);
    send_request(ACT_LOOKUP, 22'd0, 8'd2, 16'd0, 2'd0);
    send_request(ACT_LOOKUP, 22'd0, 8'd4, 16'd0, 2'd0);
    send_request(ACT_LOOKUP, 22'd0, 8'd6, 16'd0, 2'd0);
    send_request(ACT_LOOKUP, 22'd0, 8'd64, 16'd0, 2'd0);
    send_request(ACT_LOOKUP, 22'd0, 8'd255, 16'd0, 2'd0);
    send_request(ACT_LOOKUP, 22'd0, 8'd7, 16'd0, 2'd0);
    send_request(ACT_CLOSE, 22'd0, 8'd1, 16'd0, 2'd0);
    send_request(ACT_CLOSE, 22'd0, 8'd4, 16'd0, 2'd0);
    send_request(ACT_OPEN, 22'd0, 8'd0, 16'h0F0F, MODE_RW);
    send_request(ACT_CLOSE, 22'h3FFFFF, 8'd3, 16'd0, 2'd0);
    send_request(ACT_LOOKUP, 22'h3FFFFF, 8'd3, 16'd0, 2'd0);
    for (int f = 3; f <= 6; f++) send_request(ACT_CLOSE, 22'd0, DescInW'(f), 16'd0, 2'd0);

    // The fill phase below starts under the receiver hold-off.
    pressure_on = 1'b1;

    // Fill one process up to a full descriptor table, then empty it again.
    for (int i = 0; i <= NumFds - StdFds; i++) begin
      send_request(ACT_OPEN, 22'h2AAAAA, 8'd0, InodeW'($urandom_range(16'hFFFF)),
                   ModeW'($urandom_range(3)));
    end
    s = fd_model.find_slot(22'h2AAAAA);
    for (int f = StdFds; f < NumFds; f++) begin
      if (s >= 0 && fd_model.slot_map[s][f]) begin
        send_request(ACT_CLOSE, 22'h2AAAAA, DescInW'(f), 16'd0, 2'd0);
      end
    end

    // Claim every process slot and one more, then release them.
    for (int k = 0; k <= NumSlots; k++) begin
      send_request(ACT_OPEN, ProcIdW'(100 + k), 8'd0, InodeW'($urandom_range(16'hFFFF)),
                   ModeW'($urandom_range(3)));
    end
    for (int k = 0; k <= NumSlots; k++) begin
      send_request(ACT_CLOSE, ProcIdW'(100 + k), 8'd3, 16'd0, 2'd0);
    end

    // Random phases with different idle patterns on each side.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 81; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 81; end
        default: begin tx_idle_pct = 22; rx_stall_pct = 22; end
      endcase
      repeat (PhaseItems) send_random_request();
    end
    in_valid_i <= 1'b0;

    // Drain the remaining results, then allow for any late output.
    while (fd_model.expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (fd_model.err_count == 0 && fd_model.expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// ===== per_process_fd_allocator_unit.f =====
rtl/core/fda_pkg.sv
rtl/core/fda_ram.sv
rtl/core/fda_probe.sv
rtl/core/per_process_fd_allocator_unit.sv
test/tb_top.sv
